[rtl/bpp_pkg.sv]
// Shared types and constants for the blood pressure CSV parser.
package bpp_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned ValW  = 16;
  localparam int unsigned MagW  = 15;
  localparam int unsigned CatW  = 3;
  localparam int unsigned NumFields = 3;

  localparam logic [MagW-1:0] MagMax = 15'd32767;

  // character codes
  localparam logic [DataW-1:0] ChNul   = 8'h00;
  localparam logic [DataW-1:0] ChComma = 8'h2C;
  localparam logic [DataW-1:0] ChPlus  = 8'h2B;
  localparam logic [DataW-1:0] ChMinus = 8'h2D;
  localparam logic [DataW-1:0] ChSpace = 8'h20;
  localparam logic [DataW-1:0] ChTab   = 8'h09;
  localparam logic [DataW-1:0] ChCr    = 8'h0D;
  localparam logic [DataW-1:0] ChZero  = 8'h30;
  localparam logic [DataW-1:0] ChNine  = 8'h39;

  // category thresholds
  localparam logic signed [ValW-1:0] SysLow      = 16'sd90;
  localparam logic signed [ValW-1:0] DiaLow      = 16'sd60;
  localparam logic signed [ValW-1:0] SysDesHi    = 16'sd119;
  localparam logic signed [ValW-1:0] DiaDesHi    = 16'sd79;
  localparam logic signed [ValW-1:0] SysPreLo    = 16'sd120;
  localparam logic signed [ValW-1:0] SysPreHi    = 16'sd139;
  localparam logic signed [ValW-1:0] DiaPreLo    = 16'sd80;
  localparam logic signed [ValW-1:0] DiaPreHi    = 16'sd89;
  localparam logic signed [ValW-1:0] SysSt1Lo    = 16'sd140;
  localparam logic signed [ValW-1:0] SysSt1Hi    = 16'sd159;
  localparam logic signed [ValW-1:0] DiaSt1Lo    = 16'sd90;
  localparam logic signed [ValW-1:0] DiaSt1Hi    = 16'sd99;
  localparam logic signed [ValW-1:0] SysSt2Lo    = 16'sd160;
  localparam logic signed [ValW-1:0] SysSt2Hi    = 16'sd179;
  localparam logic signed [ValW-1:0] DiaSt2Lo    = 16'sd100;
  localparam logic signed [ValW-1:0] DiaSt2Hi    = 16'sd109;
  localparam logic signed [ValW-1:0] SysCrisis   = 16'sd180;
  localparam logic signed [ValW-1:0] DiaCrisis   = 16'sd110;

  typedef enum logic [CatW-1:0] {
    CatHypotension,
    CatDesired,
    CatPrehyper,
    CatStage1,
    CatStage2,
    CatCrisis,
    CatUnknown
  } cat_e;

  typedef struct packed {
    logic signed [ValW-1:0] systolic;
    logic signed [ValW-1:0] diastolic;
    logic signed [ValW-1:0] pulse_rate;
  } bp_vals_t;

endpackage

[rtl/bpp_in_if.sv]
// Byte input channel: valid/ready with one frame character.
interface bpp_in_if import bpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/bpp_out_if.sv]
// Result channel: valid/ready with the parsed readings and category.
interface bpp_out_if import bpp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] systolic;
  logic signed [ValW-1:0] diastolic;
  logic signed [ValW-1:0] pulse_rate;
  logic [CatW-1:0]        category;

  modport source (output valid, output systolic, output diastolic, output pulse_rate,
                  output category, input ready);
  modport sink   (input valid, input systolic, input diastolic, input pulse_rate,
                  input category, output ready);
endinterface

[rtl/bpp_parse.sv]
// Tokenizer and decimal accumulator; holds the frame parse state.
module bpp_parse import bpp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [DataW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output bp_vals_t         vals_o
);

  localparam logic [2:0] PhBetween = 3'd0;
  localparam logic [2:0] PhSpace   = 3'd1;
  localparam logic [2:0] PhSign    = 3'd2;
  localparam logic [2:0] PhDigits  = 3'd3;
  localparam logic [2:0] PhSkip    = 3'd4;

  localparam logic [1:0] IdxDone = 2'd3;
  localparam int unsigned AccW = MagW + 4;

  logic [2:0]             phase_q, phase_d;
  logic [1:0]             idx_q, idx_d;
  logic [MagW-1:0]        mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic                   ended_q, ended_d;
  logic signed [ValW-1:0] val_q [NumFields];
  logic signed [ValW-1:0] val_d [NumFields];
  logic signed [ValW-1:0] closed [NumFields];

  logic signed [ValW-1:0] tok_val;
  logic                   close_hit;
  logic [2:0]             ph_eff;
  logic                   is_sp, is_sign, is_dig;
  logic [AccW-1:0]        acc;
  logic [MagW-1:0]        mag_acc;

  assign tok_val   = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign close_hit = (phase_q != PhBetween) && (idx_q != IdxDone);

  always_comb begin
    for (int i = 0; i < NumFields; i++) begin
      closed[i] = (close_hit && idx_q == 2'(i)) ? tok_val : val_q[i];
    end
  end

  assign vals_o.systolic   = closed[0];
  assign vals_o.diastolic  = closed[1];
  assign vals_o.pulse_rate = closed[2];

  assign is_sp   = (data_byte_i == ChSpace) ||
                   (data_byte_i >= ChTab && data_byte_i <= ChCr);
  assign is_sign = (data_byte_i == ChPlus) || (data_byte_i == ChMinus);
  assign is_dig  = (data_byte_i >= ChZero) && (data_byte_i <= ChNine);
  assign ph_eff  = (phase_q == PhBetween) ? PhSpace : phase_q;

  // mag*10 + digit, saturated
  assign acc     = AccW'({mag_q, 3'b000}) + AccW'({mag_q, 1'b0}) + AccW'(data_byte_i[3:0]);
  assign mag_acc = (acc > AccW'(MagMax)) ? MagMax : acc[MagW-1:0];

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    ended_d = ended_q;
    for (int i = 0; i < NumFields; i++) val_d[i] = val_q[i];

    if (en_i) begin
      if (last_byte_i) begin
        phase_d = PhBetween;
        idx_d   = '0;
        mag_d   = '0;
        neg_d   = 1'b0;
        ended_d = 1'b0;
        for (int i = 0; i < NumFields; i++) val_d[i] = '0;
      end else if (!ended_q) begin
        if (data_byte_i == ChNul || data_byte_i == ChComma) begin
          for (int i = 0; i < NumFields; i++) val_d[i] = closed[i];
          idx_d   = idx_q + 2'(close_hit);
          phase_d = PhBetween;
          mag_d   = '0;
          neg_d   = 1'b0;
          if (data_byte_i == ChNul) ended_d = 1'b1;
        end else if (ph_eff == PhSpace && is_sp) begin
          phase_d = PhSpace;
        end else if (ph_eff == PhSpace && is_sign) begin
          neg_d   = (data_byte_i == ChMinus);
          phase_d = PhSign;
        end else if (ph_eff == PhSpace || ph_eff == PhSign || ph_eff == PhDigits) begin
          if (is_dig) begin
            mag_d   = mag_acc;
            phase_d = PhDigits;
          end else begin
            phase_d = PhSkip;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhBetween;
      idx_q   <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      ended_q <= 1'b0;
      for (int i = 0; i < NumFields; i++) val_q[i] <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      ended_q <= ended_d;
      for (int i = 0; i < NumFields; i++) val_q[i] <= val_d[i];
    end
  end

endmodule

[rtl/bpp_classify.sv]
// Pressure category from systolic and diastolic readings.
module bpp_classify import bpp_pkg::*; (
  input  logic signed [ValW-1:0] systolic_i,
  input  logic signed [ValW-1:0] diastolic_i,
  output cat_e                   category_o
);

  always_comb begin
    if (systolic_i < SysLow || diastolic_i < DiaLow) begin
      category_o = CatHypotension;
    end else if (systolic_i <= SysDesHi && diastolic_i <= DiaDesHi) begin
      category_o = CatDesired;
    end else if ((systolic_i >= SysPreLo && systolic_i <= SysPreHi) ||
                 (diastolic_i >= DiaPreLo && diastolic_i <= DiaPreHi)) begin
      category_o = CatPrehyper;
    end else if ((systolic_i >= SysSt1Lo && systolic_i <= SysSt1Hi) ||
                 (diastolic_i >= DiaSt1Lo && diastolic_i <= DiaSt1Hi)) begin
      category_o = CatStage1;
    end else if ((systolic_i >= SysSt2Lo && systolic_i <= SysSt2Hi) ||
                 (diastolic_i >= DiaSt2Lo && diastolic_i <= DiaSt2Hi)) begin
      category_o = CatStage2;
    end else if (systolic_i >= SysCrisis || diastolic_i >= DiaCrisis) begin
      category_o = CatCrisis;
    end else begin
      category_o = CatUnknown;
    end
  end

endmodule

[rtl/csv_blood_pressure_parser.sv]
// Top level: input register, parser state, category logic, result register.
//
//   channel  dir  payload                                    transfer
//   in_i     in   data_byte, last_byte                       valid & ready
//   out_o    out  systolic, diastolic, pulse_rate, category  valid & ready
//
// One byte per cycle sustained unless a last byte waits (see below). A byte is
// registered, then the parser state updates from it; a last byte loads the
// result register in the same cycle as that update, after the input register.
// Reset clears all parse state; the result register is empty after reset.
// A last byte waits in the input register while the result register is full and not taken,
// and holds off the bytes behind it; other bytes never wait.
module csv_blood_pressure_parser import bpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpp_in_if.sink     in_i,
  bpp_out_if.source  out_o
);

  logic             s1_valid_q;
  logic [DataW-1:0] s1_byte_q;
  logic             s1_last_q;
  logic             out_valid_q;
  bp_vals_t         out_vals_q;
  cat_e             out_cat_q;

  logic     out_free;
  logic     s1_adv;
  bp_vals_t vals;
  cat_e     cat;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  bpp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (s1_adv),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .vals_o      (vals)
  );

  bpp_classify u_classify (
    .systolic_i  (vals.systolic),
    .diastolic_i (vals.diastolic),
    .category_o  (cat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && s1_last_q) begin
      out_vals_q <= vals;
      out_cat_q  <= cat;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.systolic   = out_vals_q.systolic;
  assign out_o.diastolic  = out_vals_q.diastolic;
  assign out_o.pulse_rate = out_vals_q.pulse_rate;
  assign out_o.category   = out_cat_q;

endmodule
